/* src/ttb_pkg.sv */
`default_nettype none

package ttb_pkg;

   localparam int DEF_TILE_WIDTH  = 64;
   localparam int DEF_TILE_HEIGHT = 64;
   localparam int DEF_SCREEN_SIZE = 512;
   localparam int QUEUE_DEPTH     = 2;

   localparam int VTX_W       = 16;
   localparam int FRAC_W      = 4;
   localparam int BOX_W       = 14;
   localparam int CLIP_POS_W  = 9;
   localparam int CLIP_SIZE_W = 10;
   localparam int IDX_W       = 6;
   localparam int POS_W       = 9;
   localparam int SIZE_W      = 7;
   localparam int ADDR_W      = 4;
   localparam int DATA_W      = 32;

   localparam logic [CLIP_POS_W-1:0]  CLIP_POS_RESET  = '0;
   localparam logic [CLIP_SIZE_W-1:0] CLIP_SIZE_RESET = 10'd512;

   typedef enum logic [1:0] {
      REG_CLIP_X,
      REG_CLIP_Y,
      REG_CLIP_WIDTH,
      REG_CLIP_HEIGHT
   } reg_addr_type;

endpackage

`default_nettype wire

/* src/triangle_tile_binner.sv */
// triangle_tile_binner
// The req channel takes one triangle per word: three vertices, signed 12.4
// fixed point. The rsp channel returns the tiles the clipped bounding box
// covers, in row-major order, one word per tile, last set on the final one.
// A triangle whose clipped box is empty returns a single word with accepted
// low and last high.
// The front stage registers the box when it takes a triangle, computes the
// tile-aligned start in its quotient state and offers both to a 2-entry
// queue in its push state; the back stage loads a box and then emits one
// tile per cycle into the output register while that register is free or
// rsp_ready is high. The front takes a new triangle only after it has
// pushed the last one into the queue.
// When rsp_ready is low the output word holds, the tile walk pauses, and the
// front keeps accepting until the queue fills.
// The csr port holds the scissor; write it only while the block is idle.
// Reset clears the queue and output valid and sets the scissor to 0, 0,
// 512 by 512.
`default_nettype none

module triangle_tile_binner import ttb_pkg::*; #(
   parameter int TILE_WIDTH  = DEF_TILE_WIDTH,
   parameter int TILE_HEIGHT = DEF_TILE_HEIGHT,
   parameter int SCREEN_SIZE = DEF_SCREEN_SIZE
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [VTX_W-1:0] req_v0_x,
   input  logic signed [VTX_W-1:0] req_v0_y,
   input  logic signed [VTX_W-1:0] req_v1_x,
   input  logic signed [VTX_W-1:0] req_v1_y,
   input  logic signed [VTX_W-1:0] req_v2_x,
   input  logic signed [VTX_W-1:0] req_v2_y,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_accepted,
   output logic [IDX_W-1:0]        rsp_tile_index,
   output logic [POS_W-1:0]        rsp_tile_x,
   output logic [POS_W-1:0]        rsp_tile_y,
   output logic [SIZE_W-1:0]       rsp_tile_width,
   output logic [SIZE_W-1:0]       rsp_tile_height,
   output logic                    rsp_last,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [ADDR_W-1:0]       csr_paddr,
   input  logic [DATA_W-1:0]       csr_pwdata,
   output logic [DATA_W-1:0]       csr_prdata,
   output logic                    csr_pready
);

   localparam int PW    = $clog2(SCREEN_SIZE + 1);
   localparam int JOB_W = 1 + 6 * PW;

   logic [CLIP_POS_W-1:0]  clip_x_ff, clip_x_in, clip_y_ff, clip_y_in;
   logic [CLIP_SIZE_W-1:0] clip_w_ff, clip_w_in, clip_h_ff, clip_h_in;
   logic                   csr_write;
   reg_addr_type           csr_reg;

   logic             push_valid, push_ready, pop_valid, pop_ready;
   logic [JOB_W-1:0] push_data, pop_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = reg_addr_type'(csr_paddr[ADDR_W-1:2]);

   always_comb begin
      clip_x_in = clip_x_ff;
      clip_y_in = clip_y_ff;
      clip_w_in = clip_w_ff;
      clip_h_in = clip_h_ff;
      if (csr_write) begin
         unique case (csr_reg)
            REG_CLIP_X:      clip_x_in = CLIP_POS_W'(csr_pwdata);
            REG_CLIP_Y:      clip_y_in = CLIP_POS_W'(csr_pwdata);
            REG_CLIP_WIDTH:  clip_w_in = CLIP_SIZE_W'(csr_pwdata);
            REG_CLIP_HEIGHT: clip_h_in = CLIP_SIZE_W'(csr_pwdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         REG_CLIP_X:      csr_prdata = DATA_W'(clip_x_ff);
         REG_CLIP_Y:      csr_prdata = DATA_W'(clip_y_ff);
         REG_CLIP_WIDTH:  csr_prdata = DATA_W'(clip_w_ff);
         REG_CLIP_HEIGHT: csr_prdata = DATA_W'(clip_h_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_x_ff <= CLIP_POS_RESET;
         clip_y_ff <= CLIP_POS_RESET;
         clip_w_ff <= CLIP_SIZE_RESET;
         clip_h_ff <= CLIP_SIZE_RESET;
      end else begin
         clip_x_ff <= clip_x_in;
         clip_y_ff <= clip_y_in;
         clip_w_ff <= clip_w_in;
         clip_h_ff <= clip_h_in;
      end
   end

   ttb_front #(
      .TILE_WIDTH  (TILE_WIDTH),
      .TILE_HEIGHT (TILE_HEIGHT),
      .SCREEN_SIZE (SCREEN_SIZE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .v0_x        (req_v0_x),
      .v0_y        (req_v0_y),
      .v1_x        (req_v1_x),
      .v1_y        (req_v1_y),
      .v2_x        (req_v2_x),
      .v2_y        (req_v2_y),
      .clip_x      (clip_x_ff),
      .clip_y      (clip_y_ff),
      .clip_width  (clip_w_ff),
      .clip_height (clip_h_ff),
      .job_valid   (push_valid),
      .job_ready   (push_ready),
      .job_data    (push_data)
   );

   ttb_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   ttb_back #(
      .TILE_WIDTH  (TILE_WIDTH),
      .TILE_HEIGHT (TILE_HEIGHT),
      .SCREEN_SIZE (SCREEN_SIZE)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (pop_valid),
      .job_ready       (pop_ready),
      .job_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_accepted    (rsp_accepted),
      .rsp_tile_index  (rsp_tile_index),
      .rsp_tile_x      (rsp_tile_x),
      .rsp_tile_y      (rsp_tile_y),
      .rsp_tile_width  (rsp_tile_width),
      .rsp_tile_height (rsp_tile_height),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

/* src/ttb_front.sv */
`default_nettype none

module ttb_front import ttb_pkg::*; #(
   parameter int TILE_WIDTH  = DEF_TILE_WIDTH,
   parameter int TILE_HEIGHT = DEF_TILE_HEIGHT,
   parameter int SCREEN_SIZE = DEF_SCREEN_SIZE,
   localparam int PW    = $clog2(SCREEN_SIZE + 1),
   localparam int JOB_W = 1 + 6 * PW
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [VTX_W-1:0] v0_x,
   input  logic signed [VTX_W-1:0] v0_y,
   input  logic signed [VTX_W-1:0] v1_x,
   input  logic signed [VTX_W-1:0] v1_y,
   input  logic signed [VTX_W-1:0] v2_x,
   input  logic signed [VTX_W-1:0] v2_y,
   input  logic [CLIP_POS_W-1:0]   clip_x,
   input  logic [CLIP_POS_W-1:0]   clip_y,
   input  logic [CLIP_SIZE_W-1:0]  clip_width,
   input  logic [CLIP_SIZE_W-1:0]  clip_height,
   output logic                    job_valid,
   input  logic                    job_ready,
   output logic [JOB_W-1:0]        job_data
);

   localparam int QW    = $clog2(SCREEN_SIZE);
   localparam int KX    = QW + $clog2(TILE_WIDTH);
   localparam int KY    = QW + $clog2(TILE_HEIGHT);
   localparam int MX    = ((1 << KX) + TILE_WIDTH - 1) / TILE_WIDTH;
   localparam int MY    = ((1 << KY) + TILE_HEIGHT - 1) / TILE_HEIGHT;
   localparam int PRW   = 2 * QW + 1;
   localparam int SUM_W = CLIP_SIZE_W + 1;

   typedef enum logic [1:0] {ST_IDLE, ST_QUOT, ST_PUSH} state_type;

   state_type state_ff;

   logic signed [VTX_W-1:0] mnx, mxx, mny, mxy;
   logic signed [VTX_W:0]   mxx_up, mxy_up;
   logic signed [BOX_W-1:0] flx, fly, clx, cly;
   logic signed [BOX_W-1:0] cx0, cy0, cx1, cy1;
   logic signed [BOX_W-1:0] bx0, by0, bx1, by1;
   logic [SUM_W-1:0]        sum_x, sum_y;
   logic                    box_empty;

   logic            empty_ff;
   logic [PW-1:0]   x0_ff, y0_ff, x1_ff, y1_ff;
   logic [QW-1:0]   qx_ff, qy_ff;
   logic [PRW-1:0]  prod_x, prod_y;
   logic [PW-1:0]   fx, fy;

   // bounding box, floor of min and ceil of max
   always_comb begin
      mnx = v0_x;
      mxx = v0_x;
      mny = v0_y;
      mxy = v0_y;
      if (v1_x < mnx) mnx = v1_x;
      if (v2_x < mnx) mnx = v2_x;
      if (v1_x > mxx) mxx = v1_x;
      if (v2_x > mxx) mxx = v2_x;
      if (v1_y < mny) mny = v1_y;
      if (v2_y < mny) mny = v2_y;
      if (v1_y > mxy) mxy = v1_y;
      if (v2_y > mxy) mxy = v2_y;
      mxx_up = (VTX_W + 1)'(mxx) + (VTX_W + 1)'(15);
      mxy_up = (VTX_W + 1)'(mxy) + (VTX_W + 1)'(15);
      flx = BOX_W'(mnx >>> FRAC_W);
      fly = BOX_W'(mny >>> FRAC_W);
      clx = BOX_W'(mxx_up >>> FRAC_W);
      cly = BOX_W'(mxy_up >>> FRAC_W);
   end

   // scissor, far edge saturated at the screen
   always_comb begin
      sum_x = SUM_W'(clip_x) + SUM_W'(clip_width);
      sum_y = SUM_W'(clip_y) + SUM_W'(clip_height);
      cx0 = $signed(BOX_W'(clip_x));
      cy0 = $signed(BOX_W'(clip_y));
      cx1 = (BOX_W'(sum_x) > BOX_W'(SCREEN_SIZE)) ? $signed(BOX_W'(SCREEN_SIZE))
                                                  : $signed(BOX_W'(sum_x));
      cy1 = (BOX_W'(sum_y) > BOX_W'(SCREEN_SIZE)) ? $signed(BOX_W'(SCREEN_SIZE))
                                                  : $signed(BOX_W'(sum_y));
      bx0 = (flx > cx0) ? flx : cx0;
      by0 = (fly > cy0) ? fly : cy0;
      bx1 = (clx < cx1) ? clx : cx1;
      by1 = (cly < cy1) ? cly : cy1;
      box_empty = (bx0 >= bx1) || (by0 >= by1);
   end

   // tile-aligned start by reciprocal multiply
   assign prod_x = PRW'(x0_ff[QW-1:0]) * PRW'(MX);
   assign prod_y = PRW'(y0_ff[QW-1:0]) * PRW'(MY);
   assign fx     = PW'(PW'(qx_ff) * PW'(TILE_WIDTH));
   assign fy     = PW'(PW'(qy_ff) * PW'(TILE_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_QUOT;
                  empty_ff <= box_empty;
                  x0_ff    <= PW'(bx0);
                  y0_ff    <= PW'(by0);
                  x1_ff    <= PW'(bx1);
                  y1_ff    <= PW'(by1);
               end
            end
            ST_QUOT: begin
               qx_ff    <= QW'(prod_x >> KX);
               qy_ff    <= QW'(prod_y >> KY);
               state_ff <= ST_PUSH;
            end
            ST_PUSH: begin
               if (job_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign job_valid = (state_ff == ST_PUSH);
   assign job_data  = {empty_ff, x0_ff, y0_ff, x1_ff, y1_ff, fx, fy};

endmodule

`default_nettype wire

/* src/ttb_queue.sv */
`default_nettype none

module ttb_queue import ttb_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

/* src/ttb_back.sv */
`default_nettype none

module ttb_back import ttb_pkg::*; #(
   parameter int TILE_WIDTH  = DEF_TILE_WIDTH,
   parameter int TILE_HEIGHT = DEF_TILE_HEIGHT,
   parameter int SCREEN_SIZE = DEF_SCREEN_SIZE,
   localparam int PW    = $clog2(SCREEN_SIZE + 1),
   localparam int JOB_W = 1 + 6 * PW
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  logic [JOB_W-1:0]  job_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_accepted,
   output logic [IDX_W-1:0]  rsp_tile_index,
   output logic [POS_W-1:0]  rsp_tile_x,
   output logic [POS_W-1:0]  rsp_tile_y,
   output logic [SIZE_W-1:0] rsp_tile_width,
   output logic [SIZE_W-1:0] rsp_tile_height,
   output logic              rsp_last
);

   localparam int CW = $clog2(SCREEN_SIZE + TILE_WIDTH + TILE_HEIGHT);

   logic          busy_ff, busy_in;
   logic [CW-1:0] x0_ff, x0_in, y0_ff, y0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic [CW-1:0] fx_ff, fx_in;
   logic [CW-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [IDX_W-1:0] n_ff, n_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_accepted_ff, rsp_accepted_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [POS_W-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [SIZE_W-1:0] rsp_w_ff, rsp_w_in, rsp_h_ff, rsp_h_in;
   logic              rsp_last_ff, rsp_last_in;

   logic          advance;
   logic          job_empty;
   logic [CW-1:0] rx_end, ry_end, tx0, ty0, tx1, ty1;
   logic          last_col, last_row, tile_last;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign job_ready = advance && !busy_ff;
   assign job_empty = job_data[JOB_W-1];

   // current tile clipped to the box
   always_comb begin
      rx_end    = rx_ff + CW'(TILE_WIDTH);
      ry_end    = ry_ff + CW'(TILE_HEIGHT);
      tx0       = (rx_ff > x0_ff) ? rx_ff : x0_ff;
      ty0       = (ry_ff > y0_ff) ? ry_ff : y0_ff;
      tx1       = (rx_end < x1_ff) ? rx_end : x1_ff;
      ty1       = (ry_end < y1_ff) ? ry_end : y1_ff;
      last_col  = (rx_end >= x1_ff);
      last_row  = (ry_end >= y1_ff);
      tile_last = (last_col && last_row) || (&n_ff);
   end

   always_comb begin
      busy_in = busy_ff;
      x0_in   = x0_ff;
      y0_in   = y0_ff;
      x1_in   = x1_ff;
      y1_in   = y1_ff;
      fx_in   = fx_ff;
      rx_in   = rx_ff;
      ry_in   = ry_ff;
      n_in    = n_ff;

      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_x_in        = rsp_x_ff;
      rsp_y_in        = rsp_y_ff;
      rsp_w_in        = rsp_w_ff;
      rsp_h_in        = rsp_h_ff;
      rsp_last_in     = rsp_last_ff;

      if (advance && busy_ff) begin
         rsp_valid_in    = 1'b1;
         rsp_accepted_in = 1'b1;
         rsp_index_in    = n_ff;
         rsp_x_in        = POS_W'(tx0);
         rsp_y_in        = POS_W'(ty0);
         rsp_w_in        = SIZE_W'(tx1 - tx0);
         rsp_h_in        = SIZE_W'(ty1 - ty0);
         rsp_last_in     = tile_last;
         n_in            = n_ff + 1'b1;
         if (tile_last) begin
            busy_in = 1'b0;
         end else if (last_col) begin
            rx_in = fx_ff;
            ry_in = ry_end;
         end else begin
            rx_in = rx_end;
         end
      end else if (job_ready && job_valid) begin
         if (job_empty) begin
            rsp_valid_in    = 1'b1;
            rsp_accepted_in = 1'b0;
            rsp_index_in    = '0;
            rsp_x_in        = '0;
            rsp_y_in        = '0;
            rsp_w_in        = '0;
            rsp_h_in        = '0;
            rsp_last_in     = 1'b1;
         end else begin
            busy_in = 1'b1;
            x0_in   = CW'(job_data[6*PW-1 -: PW]);
            y0_in   = CW'(job_data[5*PW-1 -: PW]);
            x1_in   = CW'(job_data[4*PW-1 -: PW]);
            y1_in   = CW'(job_data[3*PW-1 -: PW]);
            fx_in   = CW'(job_data[2*PW-1 -: PW]);
            rx_in   = CW'(job_data[2*PW-1 -: PW]);
            ry_in   = CW'(job_data[PW-1 -: PW]);
            n_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff           <= x0_in;
      y0_ff           <= y0_in;
      x1_ff           <= x1_in;
      y1_ff           <= y1_in;
      fx_ff           <= fx_in;
      rx_ff           <= rx_in;
      ry_ff           <= ry_in;
      n_ff            <= n_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_x_ff        <= rsp_x_in;
      rsp_y_ff        <= rsp_y_in;
      rsp_w_ff        <= rsp_w_in;
      rsp_h_ff        <= rsp_h_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_tile_index  = rsp_index_ff;
   assign rsp_tile_x      = rsp_x_ff;
   assign rsp_tile_y      = rsp_y_ff;
   assign rsp_tile_width  = rsp_w_ff;
   assign rsp_tile_height = rsp_h_ff;
   assign rsp_last        = rsp_last_ff;

   a_tile_nonempty: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && advance) |-> ((tx1 > tx0) && (ty1 > ty0)))
      else $error("emitted tile has no area");

   a_walk_inside: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ((rx_ff < x1_ff) && (ry_ff < y1_ff)))
      else $error("tile walk left the box");

endmodule

`default_nettype wire
